// ----- rtl/dde_pkg.sv -----
package dde_pkg;

  localparam int BINS      = 32;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 5;
  localparam int PROB_W    = 17;
  localparam int ACC_W     = 28;
  localparam int DIV_W     = ACC_W + 8;

  localparam logic [PROB_W-1:0] ONE_P = PROB_W'(1 << FRAC_BITS);

  localparam logic [2:0] CMD_WR_A  = 3'd0;
  localparam logic [2:0] CMD_WR_B  = 3'd1;
  localparam logic [2:0] CMD_RD_A  = 3'd2;
  localparam logic [2:0] CMD_CONV  = 3'd3;
  localparam logic [2:0] CMD_CLAMP = 3'd4;
  localparam logic [2:0] CMD_TAIL  = 3'd5;
  localparam logic [2:0] CMD_MEAN  = 3'd6;
  localparam logic [2:0] CMD_RSVD  = 3'd7;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ZERO_WEIGHT = 2'd1;
  localparam logic [1:0] ST_FOLDED      = 2'd2;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [IDX_W-1:0]  bin_index;
    logic [PROB_W-1:0] prob;
    logic [IDX_W-1:0]  operand_value;
  } in_word_t;

  typedef struct packed {
    logic [PROB_W-1:0] result;
    logic [1:0]        status;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

// ----- rtl/dde_div.sv -----
module dde_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dde_pkg::div_req_t        req,
  output logic                     done,
  output logic [dde_pkg::DIV_W-1:0] quot
);
  import dde_pkg::*;

  // restoring division, one quotient bit per cycle
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] den_r;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
    if (req.start) begin
      q_nxt    = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 6'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/discrete_distribution_engine_unit.sv -----
// Discrete distribution engine: two 32-bin Q1.16 distributions in RAM.
// Flow: write and unused command go straight to the result state, read passes S_RD;
//   clamp/tail scan from operand_value up, mean scans all 32 bins, then divides unless the weight is zero,
//   convolve clears scratch, runs every bin-pair MAC, drains and copies back saturating.
// Throughput: one command at a time; busy drops in the cycle out_valid is high.
// Reset (sync, rst_n low): sweep both RAMs to the unit distribution
//   with busy high; results cannot be stalled by the receiver.
module discrete_distribution_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dde_pkg::in_word_t   in_word,
  output logic                out_valid,
  output dde_pkg::out_word_t  out_word
);
  import dde_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_CLRW  = 4'd4;
  localparam logic [3:0] S_CONVA = 4'd5;
  localparam logic [3:0] S_CONVB = 4'd6;
  localparam logic [3:0] S_COPY  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // memories: A, B and the convolution accumulator (scratch)
  logic [PROB_W-1:0] mem_a [BINS];
  logic [PROB_W-1:0] mem_b [BINS];
  logic [ACC_W-1:0]  mem_s [BINS];
  logic [PROB_W-1:0] rd_a_r, rd_b_r;
  logic [ACC_W-1:0]  rd_s_r;

  logic [3:0]        state_r, state_nxt;
  in_word_t          cmd_r, cmd_nxt;
  logic [IDX_W:0]    i_r, i_nxt, j_r, j_nxt;
  logic [ACC_W-1:0]  sum_r, sum_nxt, wsum_r, wsum_nxt;
  logic [PROB_W-1:0] res_r, res_nxt;
  logic              flag_r, flag_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              phase_r, phase_nxt;

  // RAM controls
  logic              a_we, b_we, s_we;
  logic [IDX_W-1:0]  a_wa, b_wa, s_wa, a_ra, b_ra, s_ra;
  logic [PROB_W-1:0] a_wd, b_wd;
  logic [ACC_W-1:0]  s_wd;

  // pipeline of the convolve MAC: read, multiply, accumulate
  logic              p1_v_r, p2_v_r;
  logic [IDX_W-1:0]  p1_k_r, p2_k_r;
  logic              p1_fold_r, p2_fold_r;
  logic [33:0]       prod_r;
  logic [ACC_W-1:0]  fwd_r;
  logic              fwd_v_r;
  logic [IDX_W-1:0]  fwd_k_r;
  logic [ACC_W-1:0]  mac_old, mac_add;
  logic              p1_v_nxt, p1_fold_nxt;
  logic [IDX_W-1:0]  p1_k_nxt;
  logic [IDX_W+1:0]  ksum;

  div_req_t          dreq;
  logic              ddone;
  logic [DIV_W-1:0]  dquot;

  dde_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sum_nxt   = sum_r;
    wsum_nxt  = wsum_r;
    res_nxt   = res_r;
    flag_nxt  = flag_r;
    ov_nxt    = 1'b0;
    st_nxt    = st_r;
    phase_nxt = phase_r;
    a_we = 1'b0; b_we = 1'b0; s_we = 1'b0;
    a_wa = i_r[IDX_W-1:0]; b_wa = i_r[IDX_W-1:0]; s_wa = i_r[IDX_W-1:0];
    a_ra = i_r[IDX_W-1:0]; b_ra = j_r[IDX_W-1:0]; s_ra = '0;
    a_wd = '0; b_wd = '0; s_wd = '0;
    p1_v_nxt = 1'b0; p1_k_nxt = '0; p1_fold_nxt = 1'b0;
    ksum = {2'b00, i_r[IDX_W-1:0]} + {2'b00, j_r[IDX_W-1:0]};
    dreq = '0;
    unique case (state_r)
      S_INIT: begin
        a_we = 1'b1; b_we = 1'b1;
        a_wd = (i_r == '0) ? ONE_P : '0;
        b_wd = a_wd;
        i_nxt = i_r + 1'b1;
        if (i_r == (IDX_W+1)'(BINS-1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_word;
          flag_nxt = 1'b0;
          res_nxt  = '0;
          sum_nxt  = '0;
          wsum_nxt = '0;
          phase_nxt = 1'b0;
          i_nxt = '0; j_nxt = '0;
          state_nxt = S_DONE;
          case (in_word.cmd)
            CMD_WR_A, CMD_WR_B: begin
              flag_nxt = in_word.prob > ONE_P;
              a_wd = flag_nxt ? ONE_P : in_word.prob;
              b_wd = a_wd;
              a_wa = in_word.bin_index; b_wa = in_word.bin_index;
              a_we = in_word.cmd == CMD_WR_A;
              b_we = in_word.cmd == CMD_WR_B;
            end
            CMD_RD_A: begin
              a_ra = in_word.bin_index;
              state_nxt = S_RD;
            end
            CMD_CLAMP, CMD_TAIL: begin
              i_nxt = {1'b0, in_word.operand_value};
              a_ra  = in_word.operand_value;
              state_nxt = S_SCAN;
            end
            CMD_MEAN: begin
              a_ra = '0;
              state_nxt = S_SCAN;
            end
            CMD_CONV: state_nxt = S_CLRW;
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_nxt = rd_a_r;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // one bin per cycle: rd_a_r holds bin i_r
        sum_nxt  = sum_r + ACC_W'(rd_a_r);
        wsum_nxt = wsum_r + ACC_W'(i_r[IDX_W-1:0]) * ACC_W'(rd_a_r);
        a_ra = IDX_W'(i_r + 1'b1);
        if (cmd_r.cmd == CMD_CLAMP && i_r[IDX_W-1:0] != cmd_r.operand_value) begin
          a_we = 1'b1; a_wa = i_r[IDX_W-1:0]; a_wd = '0;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == (IDX_W+1)'(BINS-1)) begin
          state_nxt = S_DONE;
          if (cmd_r.cmd == CMD_CLAMP || cmd_r.cmd == CMD_TAIL) begin
            flag_nxt = sum_nxt > ACC_W'(ONE_P);
            res_nxt  = flag_nxt ? ONE_P : sum_nxt[PROB_W-1:0];
            // clamp answers 0; its merged bin is written in S_DONE
            if (cmd_r.cmd == CMD_CLAMP) res_nxt = '0;
          end else if (sum_nxt == '0) begin
            st_nxt = ST_ZERO_WEIGHT;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = {wsum_nxt, 8'h00};
            dreq.den   = DIV_W'(sum_nxt);
            state_nxt  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (ddone) begin
          res_nxt = dquot[PROB_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_CLRW: begin
        s_we = 1'b1; s_wd = '0;
        i_nxt = i_r + 1'b1;
        if (i_r == (IDX_W+1)'(BINS-1)) begin
          i_nxt = '0; j_nxt = '0;
          state_nxt = S_CONVA;
        end
      end
      S_CONVA: begin
        // issue one bin pair per cycle; scratch is read in the p1 stage
        a_ra = i_r[IDX_W-1:0]; b_ra = j_r[IDX_W-1:0];
        p1_v_nxt = 1'b1;
        p1_fold_nxt = ksum >= (IDX_W+2)'(BINS);
        p1_k_nxt = p1_fold_nxt ? IDX_W'(BINS-1) : ksum[IDX_W-1:0];
        s_ra = p1_k_r;
        j_nxt = j_r + 1'b1;
        if (j_r == (IDX_W+1)'(BINS-1)) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
          if (i_r == (IDX_W+1)'(BINS-1)) begin
            i_nxt = '0;
            state_nxt = S_CONVB;
          end
        end
      end
      S_CONVB: begin
        // drain the MAC pipeline
        s_ra = p1_k_r;
        i_nxt = i_r + 1'b1;
        if (i_r == (IDX_W+1)'(3)) begin
          i_nxt = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // phase 0 reads scratch bin i, phase 1 writes saturated value to A
        s_ra = i_r[IDX_W-1:0];
        phase_nxt = ~phase_r;
        if (phase_r) begin
          a_we = 1'b1; a_wa = i_r[IDX_W-1:0];
          a_wd = (rd_s_r > ACC_W'(ONE_P)) ? ONE_P : rd_s_r[PROB_W-1:0];
          if (rd_s_r > ACC_W'(ONE_P)) flag_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
          if (i_r == (IDX_W+1)'(BINS-1)) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // clamp: land the merged mass in bin operand_value
        if (cmd_r.cmd == CMD_CLAMP) begin
          a_we = 1'b1; a_wa = cmd_r.operand_value;
          a_wd = flag_r ? ONE_P : sum_r[PROB_W-1:0];
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (p2_v_r && p2_fold_r && prod_r[33:FRAC_BITS] != '0) flag_nxt = 1'b1;
    if (state_r == S_IDLE && start) st_nxt = ST_OK;
  end

  // MAC: accumulate into scratch, forwarding the previous write
  assign mac_old = (fwd_v_r && fwd_k_r == p2_k_r) ? fwd_r : rd_s_r;
  assign mac_add = mac_old + ACC_W'(prod_r[33:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_wa] <= a_wd;
    if (b_we) mem_b[b_wa] <= b_wd;
    if (p2_v_r) mem_s[p2_k_r] <= mac_add;
    else if (s_we) mem_s[s_wa] <= s_wd;
    rd_a_r <= mem_a[a_ra];
    rd_b_r <= mem_b[b_ra];
    rd_s_r <= mem_s[s_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      i_r     <= '0;
      j_r     <= '0;
      ov_r    <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      phase_r <= 1'b0;
      flag_r  <= 1'b0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      ov_r    <= ov_nxt;
      p1_v_r  <= p1_v_nxt;
      p2_v_r  <= p1_v_r;
      fwd_v_r <= p2_v_r;
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      st_r    <= st_nxt;
    end
    cmd_r     <= cmd_nxt;
    sum_r     <= sum_nxt;
    wsum_r    <= wsum_nxt;
    res_r     <= res_nxt;
    p1_k_r    <= p1_k_nxt;
    p1_fold_r <= p1_fold_nxt;
    p2_k_r    <= p1_k_r;
    p2_fold_r <= p1_fold_r;
    prod_r    <= 34'(rd_a_r) * 34'(rd_b_r);
    fwd_r     <= mac_add;
    fwd_k_r   <= p2_k_r;
  end

  // scratch bin k is read while its pair sits in p1, so rd_s_r lines up with
  // p2. The write of the pair just ahead lands on the same edge as that read,
  // so a same-bin hit one back takes fwd_r; a hit two back lands through the RAM.
  assign busy              = state_r != S_IDLE;
  assign out_valid         = ov_r;
  assign out_word.result   = res_r;
  assign out_word.status   = flag_r ? ST_FOLDED : st_r;

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_mac_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> (state_r == S_CONVA || state_r == S_CONVB))
    else $error("MAC active outside convolution");

endmodule
